>>> rtl/vrp_pkg.sv
// Shared types, widths, register codes and the CORDIC arctangent table.
`default_nettype none

package vrp_pkg;

    localparam int TRIG_STAGES_DEF = 16;

    // Coordinate width (Q.22) and trig width (Q2.30), both with headroom.
    localparam int VW = 34;
    localparam int TW = 34;
    // Divider: quotient bits, divisor bits, dividend / remainder bits.
    localparam int QW = 33;
    localparam int DW = 39;
    localparam int RW = 65;
    localparam int ADDR_W = 5;

    localparam logic signed [TW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TW-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [TW-1:0] HALF_TURN = 34'sd2147483648;

    localparam logic [2:0] REG_ANGLE_X = 3'd0;
    localparam logic [2:0] REG_ANGLE_Y = 3'd1;
    localparam logic [2:0] REG_ANGLE_Z = 3'd2;
    localparam logic [2:0] REG_SCALE = 3'd3;
    localparam logic [2:0] REG_DEPTH = 3'd4;

    typedef struct packed {
        logic signed [TW-1:0] x;
        logic signed [TW-1:0] y;
        logic signed [TW-1:0] z;
        logic                 neg;
    } cordic_t;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [DW-1:0] dvs;
        logic [QW-1:0] quo;
        logic          ovf;
    } div_state_t;

    // Arctangent of 2^-idx, 2^32 units per turn.
    function automatic logic [31:0] atan_step(input int idx);
        logic [31:0] r;
        unique case (idx)
            0: r = 32'd536870912;
            1: r = 32'd316933406;
            2: r = 32'd167458907;
            3: r = 32'd85004756;
            4: r = 32'd42667331;
            5: r = 32'd21354465;
            6: r = 32'd10679838;
            7: r = 32'd5340245;
            8: r = 32'd2670163;
            9: r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            15: r = 32'd20861;
            16: r = 32'd10430;
            17: r = 32'd5215;
            18: r = 32'd2608;
            19: r = 32'd1304;
            20: r = 32'd652;
            21: r = 32'd326;
            22: r = 32'd163;
            23: r = 32'd81;
            24: r = 32'd41;
            25: r = 32'd20;
            26: r = 32'd10;
            27: r = 32'd5;
            28: r = 32'd3;
            29: r = 32'd1;
            30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/vrp_cordic_cell.sv
// One CORDIC rotation step, registered.
`default_nettype none

module vrp_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             en,
    input  vrp_pkg::cordic_t din,
    output vrp_pkg::cordic_t dout
);

    localparam logic signed [vrp_pkg::TW-1:0] ATAN =
        $signed(vrp_pkg::TW'(vrp_pkg::atan_step(STAGE)));

    vrp_pkg::cordic_t cell_reg;
    vrp_pkg::cordic_t cell_next;

    always_comb
    begin
        cell_next.neg = din.neg;
        if (!din.z[vrp_pkg::TW-1])
        begin
            cell_next.x = din.x - (din.y >>> STAGE);
            cell_next.y = din.y + (din.x >>> STAGE);
            cell_next.z = din.z - ATAN;
        end
        else
        begin
            cell_next.x = din.x + (din.y >>> STAGE);
            cell_next.y = din.y - (din.x >>> STAGE);
            cell_next.z = din.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

>>> rtl/vrp_rotate.sv
// Plane rotation a' = a*c - b*s, b' = a*s + b*c: product stage, then round stage.
`default_nettype none

module vrp_rotate #(
    parameter int SIDE_W = 34
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [vrp_pkg::VW-1:0]   a,
    input  logic signed [vrp_pkg::VW-1:0]   b,
    input  logic signed [vrp_pkg::TW-1:0]   c,
    input  logic signed [vrp_pkg::TW-1:0]   s,
    input  logic        [SIDE_W-1:0]        side_in,
    output logic signed [vrp_pkg::VW-1:0]   a_out,
    output logic signed [vrp_pkg::VW-1:0]   b_out,
    output logic        [SIDE_W-1:0]        side_out
);

    localparam int PW = vrp_pkg::VW + vrp_pkg::TW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] ROUND = SW'(1) <<< 29;

    logic signed [PW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic        [SIDE_W-1:0] side1_reg;
    logic signed [SW-1:0] a_sum, b_sum;
    logic signed [vrp_pkg::VW-1:0] a_next, b_next;
    logic signed [vrp_pkg::VW-1:0] a_reg, b_reg;
    logic        [SIDE_W-1:0] side2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ac_reg    <= PW'(a) * PW'(c);
            bs_reg    <= PW'(b) * PW'(s);
            as_reg    <= PW'(a) * PW'(s);
            bc_reg    <= PW'(b) * PW'(c);
            side1_reg <= side_in;
        end
    end

    // Round half up at bit 30.
    always_comb
    begin
        a_sum  = SW'(ac_reg) - SW'(bs_reg) + ROUND;
        b_sum  = SW'(as_reg) + SW'(bc_reg) + ROUND;
        a_next = vrp_pkg::VW'(a_sum >>> 30);
        b_next = vrp_pkg::VW'(b_sum >>> 30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg     <= a_next;
            b_reg     <= b_next;
            side2_reg <= side1_reg;
        end
    end

    assign a_out    = a_reg;
    assign b_out    = b_reg;
    assign side_out = side2_reg;

endmodule

`default_nettype wire

>>> rtl/vrp_div_cell.sv
// One restoring-division step: resolves quotient bit BIT.
`default_nettype none

module vrp_div_cell #(
    parameter int BIT = 0
) (
    input  logic                clk,
    input  logic                en,
    input  vrp_pkg::div_state_t din,
    output vrp_pkg::div_state_t dout
);

    localparam int SW = vrp_pkg::DW + vrp_pkg::QW;

    logic [SW-1:0] shifted;
    logic [SW-1:0] rem_ext;
    logic          fits;
    vrp_pkg::div_state_t cell_reg;
    vrp_pkg::div_state_t cell_next;

    always_comb
    begin
        shifted = SW'(din.dvs) << BIT;
        rem_ext = SW'(din.rem);
        fits    = rem_ext >= shifted;
        cell_next.dvs = din.dvs;
        cell_next.ovf = din.ovf;
        cell_next.rem = fits ? vrp_pkg::RW'(rem_ext - shifted) : din.rem;
        cell_next.quo = din.quo | (fits ? (vrp_pkg::QW'(1) << BIT) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

`default_nettype wire

>>> rtl/vertex_rotate_project.sv
// Top level: scale, XYZ Euler rotation and perspective projection of vertices.
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | tdata: model_x, model_y, model_z
//  m_*     | out | m_tvalid/m_tready  | tdata: screen_x, screen_y, rotated_depth;
//          |     |                    | tuser: projection_fault
//  apb     | in  | psel/penable       | angles, side_scale, view_depth
//
// One vertex per cycle sustained while the output is not blocked. From the input
// transaction to the result appearing on m_*, a vertex passes one entry stage,
// one CORDIC cell per trig stage, a sign stage, three two-stage rotators, three
// projection setup stages and one divider cell per quotient bit (33), plus the
// output register. Reset clears configuration to its defaults and empties the pipe;
// no clearing pass. When the output register holds a result that m_tready
// does not take, every stage freezes and s_tready drops in the same cycle.
`default_nettype none

module vertex_rotate_project #(
    parameter int TRIG_STAGES = vrp_pkg::TRIG_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // model_x, model_y, model_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // screen_x, screen_y, rotated_depth
    output logic [0:0]  m_tuser,   // projection_fault
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [vrp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VW = vrp_pkg::VW;
    localparam int TW = vrp_pkg::TW;
    localparam int QW = vrp_pkg::QW;
    localparam int DW = vrp_pkg::DW;
    localparam int RW = vrp_pkg::RW;
    localparam int LAT = TRIG_STAGES + 11 + QW;
    localparam int RX_SIDE_W = VW + 4 * TW;
    localparam int RY_SIDE_W = VW + 2 * TW;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic        fault;
        logic        x_num_neg;
        logic        y_num_neg;
        logic        x_q_neg;
        logic        y_q_neg;
        logic [31:0] depth;
    } proj_side_t;

    // ---------------------------------------------------------------- config
    logic [15:0] angle_x_reg, angle_y_reg, angle_z_reg, scale_reg;
    logic [23:0] depth_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_x_reg <= '0;
            angle_y_reg <= '0;
            angle_z_reg <= '0;
            scale_reg   <= 16'd256;
            depth_reg   <= 24'd65536;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                vrp_pkg::REG_ANGLE_X: angle_x_reg <= pwdata[15:0];
                vrp_pkg::REG_ANGLE_Y: angle_y_reg <= pwdata[15:0];
                vrp_pkg::REG_ANGLE_Z: angle_z_reg <= pwdata[15:0];
                vrp_pkg::REG_SCALE:   scale_reg   <= pwdata[15:0];
                vrp_pkg::REG_DEPTH:   depth_reg   <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            vrp_pkg::REG_ANGLE_X: prdata = {16'h0, angle_x_reg};
            vrp_pkg::REG_ANGLE_Y: prdata = {16'h0, angle_y_reg};
            vrp_pkg::REG_ANGLE_Z: prdata = {16'h0, angle_z_reg};
            vrp_pkg::REG_SCALE:   prdata = {16'h0, scale_reg};
            vrp_pkg::REG_DEPTH:   prdata = {8'h0, depth_reg};
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------- flow control
    // One global advance: the whole pipe moves unless the output is blocked.
    logic           en;
    logic [LAT-1:0] vld_reg;
    logic           m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    // ---------------------------------------------------------- entry stage
    // Fold the angle into [-90, 90] degrees; a half turn flips the sign.
    function automatic vrp_pkg::cordic_t fold(input logic [15:0] ang);
        logic signed [TW-1:0] z;
        vrp_pkg::cordic_t     r;
        z     = TW'($signed({ang, 16'h0}));
        r.x   = vrp_pkg::CORDIC_GAIN;
        r.y   = '0;
        r.neg = 1'b0;
        if (z > vrp_pkg::QUARTER_TURN)
        begin
            z     = z - vrp_pkg::HALF_TURN;
            r.neg = 1'b1;
        end
        else if (z < -vrp_pkg::QUARTER_TURN)
        begin
            z     = z + vrp_pkg::HALF_TURN;
            r.neg = 1'b1;
        end
        r.z = z;
        return r;
    endfunction

    logic signed [16:0] scale_s;
    vec_t               ent_vec_reg;
    vrp_pkg::cordic_t   ent_trig_reg [3];

    assign scale_s = $signed({1'b0, scale_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_vec_reg.x   <= VW'($signed(s_tdata[15:0])) * VW'(scale_s);
            ent_vec_reg.y   <= VW'($signed(s_tdata[31:16])) * VW'(scale_s);
            ent_vec_reg.z   <= VW'($signed(s_tdata[47:32])) * VW'(scale_s);
            ent_trig_reg[0] <= fold(angle_x_reg);
            ent_trig_reg[1] <= fold(angle_y_reg);
            ent_trig_reg[2] <= fold(angle_z_reg);
        end
    end

    // ---------------------------------------------------------- CORDIC chain
    // All three angles travel alongside their vertex, one cell per step.
    vrp_pkg::cordic_t trig_w [3][TRIG_STAGES+1];
    vec_t             vec_w [TRIG_STAGES+1];
    vec_t             vec_reg [TRIG_STAGES];

    assign vec_w[0] = ent_vec_reg;

    for (genvar a = 0; a < 3; a++)
    begin : g_trig_in
        assign trig_w[a][0] = ent_trig_reg[a];
    end

    for (genvar k = 0; k < TRIG_STAGES; k++)
    begin : g_cordic
        for (genvar a = 0; a < 3; a++)
        begin : g_axis
            vrp_cordic_cell #(.STAGE(k)) u_cell (
                .clk  (clk),
                .en   (en),
                .din  (trig_w[a][k]),
                .dout (trig_w[a][k+1])
            );
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vec_reg[k] <= vec_w[k];
            end
        end

        assign vec_w[k+1] = vec_reg[k];
    end

    // ------------------------------------------------------------ sign stage
    logic signed [TW-1:0] cos_reg [3];
    logic signed [TW-1:0] sin_reg [3];
    vec_t                 nvec_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cos_reg[a] <= trig_w[a][TRIG_STAGES].neg ? -trig_w[a][TRIG_STAGES].x
                                                         : trig_w[a][TRIG_STAGES].x;
                sin_reg[a] <= trig_w[a][TRIG_STAGES].neg ? -trig_w[a][TRIG_STAGES].y
                                                         : trig_w[a][TRIG_STAGES].y;
            end
            nvec_reg <= vec_w[TRIG_STAGES];
        end
    end

    // ------------------------------------------------------------- rotations
    // About X: (y, z). About Y: (z, x). About Z: (x, y).
    logic signed [VW-1:0] rx_y, rx_z, ry_z, ry_x, rz_x, rz_y;
    logic [RX_SIDE_W-1:0] rx_side;
    logic [RY_SIDE_W-1:0] ry_side;
    logic [VW-1:0]        rz_side;

    vrp_rotate #(.SIDE_W(RX_SIDE_W)) u_rot_x (
        .clk      (clk),
        .en       (en),
        .a        (nvec_reg.y),
        .b        (nvec_reg.z),
        .c        (cos_reg[0]),
        .s        (sin_reg[0]),
        .side_in  ({nvec_reg.x, cos_reg[1], sin_reg[1], cos_reg[2], sin_reg[2]}),
        .a_out    (rx_y),
        .b_out    (rx_z),
        .side_out (rx_side)
    );

    vrp_rotate #(.SIDE_W(RY_SIDE_W)) u_rot_y (
        .clk      (clk),
        .en       (en),
        .a        (rx_z),
        .b        ($signed(rx_side[RX_SIDE_W-1 -: VW])),
        .c        ($signed(rx_side[4*TW-1 -: TW])),
        .s        ($signed(rx_side[3*TW-1 -: TW])),
        .side_in  ({rx_y, rx_side[2*TW-1:0]}),
        .a_out    (ry_z),
        .b_out    (ry_x),
        .side_out (ry_side)
    );

    vrp_rotate #(.SIDE_W(VW)) u_rot_z (
        .clk      (clk),
        .en       (en),
        .a        (ry_x),
        .b        ($signed(ry_side[RY_SIDE_W-1 -: VW])),
        .c        ($signed(ry_side[2*TW-1 -: TW])),
        .s        ($signed(ry_side[TW-1:0])),
        .side_in  (ry_z),
        .a_out    (rz_x),
        .b_out    (rz_y),
        .side_out (rz_side)
    );

    // ------------------------------------------------------- projection setup
    logic signed [VW-1:0] rz_z;
    logic signed [DW:0]   den;
    logic [VW-1:0]        abs_x, abs_y;
    logic signed [VW:0]   depth_rnd;
    proj_side_t           p1_side;

    assign rz_z = $signed(rz_side);

    always_comb
    begin
        den   = $signed({2'b00, depth_reg, 14'h0}) + (DW+1)'(rz_z);
        abs_x = rz_x[VW-1] ? VW'(-rz_x) : VW'(rz_x);
        abs_y = rz_y[VW-1] ? VW'(-rz_y) : VW'(rz_y);
        depth_rnd = ((VW+1)'(rz_z) + (VW+1)'(32)) >>> 6;
        p1_side.fault     = (den == '0);
        p1_side.x_num_neg = rz_x[VW-1];
        p1_side.y_num_neg = rz_y[VW-1];
        p1_side.x_q_neg   = rz_x[VW-1] ^ den[DW];
        p1_side.y_q_neg   = rz_y[VW-1] ^ den[DW];
        p1_side.depth     = depth_rnd[31:0];
    end

    logic [31:0]   p1_mag_x_reg, p1_mag_y_reg;
    logic [DW-1:0] p1_dmag_reg;
    proj_side_t    p1_side_reg;

    // Clamp magnitudes to 32 bits, take the divisor magnitude.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_mag_x_reg <= (|abs_x[VW-1:32]) ? 32'hFFFF_FFFF : abs_x[31:0];
            p1_mag_y_reg <= (|abs_y[VW-1:32]) ? 32'hFFFF_FFFF : abs_y[31:0];
            p1_dmag_reg  <= den[DW] ? DW'(-den) : DW'(den);
            p1_side_reg  <= p1_side;
        end
    end

    logic [55:0]   p2_prod_x_reg, p2_prod_y_reg;
    logic [DW-1:0] p2_dmag_reg;
    proj_side_t    p2_side_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_prod_x_reg <= 56'(p1_mag_x_reg) * 56'(depth_reg);
            p2_prod_y_reg <= 56'(p1_mag_y_reg) * 56'(depth_reg);
            p2_dmag_reg   <= p1_dmag_reg;
            p2_side_reg   <= p1_side_reg;
        end
    end

    // Dividend with half the divisor added for round-to-nearest; flag quotients
    // that need more than QW bits.
    logic [RW-1:0]       num_x, num_y;
    logic [DW+QW-1:0]    dvs_top;
    vrp_pkg::div_state_t p3_x_reg, p3_y_reg;
    proj_side_t          p3_side_reg;

    always_comb
    begin
        num_x   = {1'b0, p2_prod_x_reg, 8'h0} + RW'(p2_dmag_reg >> 1);
        num_y   = {1'b0, p2_prod_y_reg, 8'h0} + RW'(p2_dmag_reg >> 1);
        dvs_top = {p2_dmag_reg, QW'(0)};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_x_reg.rem <= num_x;
            p3_x_reg.dvs <= p2_dmag_reg;
            p3_x_reg.quo <= '0;
            p3_x_reg.ovf <= (DW+QW)'(num_x) >= dvs_top;
            p3_y_reg.rem <= num_y;
            p3_y_reg.dvs <= p2_dmag_reg;
            p3_y_reg.quo <= '0;
            p3_y_reg.ovf <= (DW+QW)'(num_y) >= dvs_top;
            p3_side_reg  <= p2_side_reg;
        end
    end

    // ---------------------------------------------------------- divider chain
    vrp_pkg::div_state_t div_x_w [QW+1];
    vrp_pkg::div_state_t div_y_w [QW+1];
    proj_side_t          side_w [QW+1];
    proj_side_t          side_reg [QW];

    assign div_x_w[0] = p3_x_reg;
    assign div_y_w[0] = p3_y_reg;
    assign side_w[0]  = p3_side_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        vrp_div_cell #(.BIT(QW-1-j)) u_div_x (
            .clk  (clk),
            .en   (en),
            .din  (div_x_w[j]),
            .dout (div_x_w[j+1])
        );

        vrp_div_cell #(.BIT(QW-1-j)) u_div_y (
            .clk  (clk),
            .en   (en),
            .din  (div_y_w[j]),
            .dout (div_y_w[j+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[j] <= side_w[j];
            end
        end

        assign side_w[j+1] = side_reg[j];
    end

    // ------------------------------------------------------------ output stage
    // Apply the sign and saturate; a zero divisor saturates by numerator sign.
    function automatic logic [31:0] finish(input vrp_pkg::div_state_t d,
                                           input logic num_neg,
                                           input logic q_neg,
                                           input logic fault);
        logic [QW-1:0] neg_q;
        logic [31:0]   r;
        neg_q = -d.quo;
        priority if (fault)
            r = num_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (q_neg)
            r = (d.ovf || d.quo[QW-1:31] != '0) ? 32'h8000_0000 : neg_q[31:0];
        else
            r = (d.ovf || d.quo[QW-1:31] != '0) ? 32'h7FFF_FFFF : d.quo[31:0];
        return r;
    endfunction

    logic [31:0] m_x_reg, m_y_reg, m_depth_reg;
    logic        m_fault_reg;
    proj_side_t  fin_side;

    assign fin_side = side_w[QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_x_reg     <= finish(div_x_w[QW], fin_side.x_num_neg, fin_side.x_q_neg,
                                  fin_side.fault);
            m_y_reg     <= finish(div_y_w[QW], fin_side.y_num_neg, fin_side.y_q_neg,
                                  fin_side.fault);
            m_depth_reg <= fin_side.depth;
            m_fault_reg <= fin_side.fault;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_depth_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_fault_reg;

`ifndef SYNTHESIS
    // A blocked output freezes the valid bits of every stage of the pipe.
    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved while output blocked");

    // A zero divisor always gives saturated screen coordinates.
    a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |->
            ((m_tdata[31:0] == 32'h7FFF_FFFF || m_tdata[31:0] == 32'h8000_0000) &&
             (m_tdata[63:32] == 32'h7FFF_FFFF || m_tdata[63:32] == 32'h8000_0000)))
        else $error("projection fault without saturation");

    // Rotated depth never needs more than 28 significant bits.
    a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[95:91] == 5'h00 || m_tdata[95:91] == 5'h1F))
        else $error("rotated depth out of range");
`endif

endmodule

`default_nettype wire
